// ----- hw/rtl/prqs_pkg.sv -----
// Shared constants, operation codes and sequencer states of the priority ready queue.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package prqs_pkg;

    // Fixed field widths of the words on the ports
    localparam int FUNC_W  = 2;
    localparam int ID_W    = 6;
    localparam int PRIO_W  = 6;
    localparam int TICK_W  = 63;
    localparam int COUNT_W = 7;

    // Default sizing
    localparam int DEF_MAX_THREADS   = 64;
    localparam int DEF_PRIORITY_BITS = 6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SLEEP    = 2'd0,
        FUNC_TICK     = 2'd1,
        FUNC_READY    = 2'd2,
        FUNC_DISPATCH = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLEEP,
        ST_TCK_RD,
        ST_TCK_CHK,
        ST_INS_START,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_DSP_RD,
        ST_DSP,
        ST_TOP_RD,
        ST_TOP
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/prqs_req_if.sv -----
// Request channel of the scheduler: valid/ready plus one operation word.
// Depends on prqs_pkg for field widths.
`default_nettype none

interface prqs_req_if;
    import prqs_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   thread_id;
    logic [PRIO_W-1:0] priority_req;
    logic [TICK_W-1:0] tick_value;

    modport source (output valid, output func, output thread_id, output priority_req,
                    output tick_value, input ready);
    modport sink   (input valid, input func, input thread_id, input priority_req,
                    input tick_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/prqs_rsp_if.sv -----
// Response channel of the scheduler: valid/ready plus one status word.
// Depends on prqs_pkg for field widths.
`default_nettype none

interface prqs_rsp_if;
    import prqs_pkg::*;

    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    out_thread_id;
    logic               found;
    logic [PRIO_W-1:0]  top_priority;
    logic [COUNT_W-1:0] ready_count;
    logic [COUNT_W-1:0] sleep_count;
    logic [TICK_W-1:0]  next_wake;
    logic               error;

    modport source (output valid, output out_thread_id, output found, output top_priority,
                    output ready_count, output sleep_count, output next_wake, output error,
                    input ready);
    modport sink   (input valid, input out_thread_id, input found, input top_priority,
                    input ready_count, input sleep_count, input next_wake, input error,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/prqs_ready_ram.sv -----
// Ring-buffer storage of the ready queue: head pointer, offset-to-slot wrap, one
// write and one registered read per cycle. Depends on nothing but its parameters.
`default_nettype none

module prqs_ready_ram #(
    parameter int DEPTH = 64,
    parameter int ENT_W = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH+1)-1:0]   wr_off,
    input  wire logic [ENT_W-1:0]             wr_data,
    input  wire logic [$clog2(DEPTH+1)-1:0]   rd_off,
    output logic      [ENT_W-1:0]             rd_data
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] wr_slot;
    logic [IDX_W-1:0] rd_slot;
    logic [SUM_W-1:0] wr_sum;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] wr_wrap;
    logic [SUM_W-1:0] rd_wrap;

    // Map queue offsets to physical slots, wrapping once past the end
    always_comb
    begin
        wr_sum  = SUM_W'(head_reg) + SUM_W'(wr_off);
        rd_sum  = SUM_W'(head_reg) + SUM_W'(rd_off);
        wr_wrap = (wr_sum >= SUM_W'(DEPTH)) ? (wr_sum - SUM_W'(DEPTH)) : wr_sum;
        rd_wrap = (rd_sum >= SUM_W'(DEPTH)) ? (rd_sum - SUM_W'(DEPTH)) : rd_sum;
        wr_slot = wr_wrap[IDX_W-1:0];
        rd_slot = rd_wrap[IDX_W-1:0];
    end

    // Advance head on pop
    always_comb
    begin
        head_next = head_reg;
        if (pop)
        begin
            head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    // Storage: write when asked, read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        rd_data <= mem[rd_slot];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/priority_ready_queue_with_sleep_timer_core.sv -----
// Top level of the priority ready queue with sleep timer.
// Depends on prqs_pkg, prqs_req_if, prqs_rsp_if and prqs_ready_ram.
`default_nettype none

// Thread scheduler with a priority-ordered ready queue (FIFO among equal
// priorities) and an arrival-ordered sleep list. Each request word carries one
// operation and yields exactly one response word. One operation is handled at a
// time by a small sequencer over two RAMs, each with one write port and one
// registered read port; req.ready is high only while the sequencer is idle, and
// a new request is taken while the previous response still waits. Make ready
// walks the ready queue from its tail and moves back each queued entry of lower
// priority. A timer tick reads and checks every sleeper and runs the insert walk
// for each thread that wakes, so the ordered-insert walk through the ready RAM
// sets the cost of both operations. Inserts into a full store are dropped and
// flagged in the error bit.
module priority_ready_queue_with_sleep_timer_core #(
    parameter int MAX_THREADS   = prqs_pkg::DEF_MAX_THREADS,
    parameter int PRIORITY_BITS = prqs_pkg::DEF_PRIORITY_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    prqs_req_if.sink    req,
    prqs_rsp_if.source  rsp
);
    import prqs_pkg::*;

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam int ENT_W = PRIORITY_BITS + ID_W;

    // Sequencer and operation registers
    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [ENT_W-1:0]   ent_reg, ent_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [CNT_W-1:0]   ready_cnt_reg, ready_cnt_next;
    logic [CNT_W-1:0]   sleep_cnt_reg, sleep_cnt_next;
    logic [CNT_W-1:0]   rd_i_reg, rd_i_next;
    logic [CNT_W-1:0]   wr_j_reg, wr_j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [TICK_W-1:0]  earliest_reg, earliest_next;
    logic [TICK_W-1:0]  min_reg, min_next;
    logic               err_reg, err_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic               found_reg, found_next;

    // Response register
    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic               out_found_reg, out_found_next;
    logic [PRIO_W-1:0]  out_top_reg, out_top_next;
    logic [COUNT_W-1:0] out_rcnt_reg, out_rcnt_next;
    logic [COUNT_W-1:0] out_scnt_reg, out_scnt_next;
    logic [TICK_W-1:0]  out_wake_reg, out_wake_next;
    logic               out_err_reg, out_err_next;

    // Ready RAM control
    logic               rq_pop;
    logic               rq_wr_en;
    logic [CNT_W-1:0]   rq_wr_off;
    logic [ENT_W-1:0]   rq_wr_data;
    logic [CNT_W-1:0]   rq_rd_off;
    logic [ENT_W-1:0]   rq_rd_data;

    // Sleep RAMs
    logic [ENT_W-1:0]   sleep_ent_mem [MAX_THREADS];
    logic [TICK_W-1:0]  sleep_tick_mem [MAX_THREADS];
    logic [ENT_W-1:0]   sleep_rd_ent_reg;
    logic [TICK_W-1:0]  sleep_rd_tick_reg;
    logic               sl_wr_en;
    logic [IDX_W-1:0]   sl_wr_addr;
    logic [ENT_W-1:0]   sl_wr_ent;
    logic [TICK_W-1:0]  sl_wr_tick;
    logic [IDX_W-1:0]   sl_rd_addr;

    // Decode helpers
    logic                           accept;
    logic                           ready_full;
    logic                           sleep_full;
    logic                           ready_empty;
    logic                           sleep_done;
    logic                           due;
    logic                           stop;
    logic                           k_is_one;
    logic                           load_out;
    state_t                         ins_ret;
    logic [PRIORITY_BITS-1:0]       rd_prio;
    logic [PRIORITY_BITS-1:0]       ent_prio;
    logic [PRIORITY_BITS+PRIO_W-1:0] prio_in_ext;
    logic [PRIORITY_BITS+PRIO_W-1:0] prio_out_ext;
    logic [CNT_W+COUNT_W-1:0]       rcnt_ext;
    logic [CNT_W+COUNT_W-1:0]       scnt_ext;
    logic [ENT_W-1:0]               req_ent;

    assign accept      = req.valid && req.ready;
    assign ready_full  = ready_cnt_reg == CNT_W'(MAX_THREADS);
    assign sleep_full  = sleep_cnt_reg == CNT_W'(MAX_THREADS);
    assign ready_empty = ready_cnt_reg == '0;
    assign sleep_done  = rd_i_reg == sleep_cnt_reg;
    assign due         = sleep_rd_tick_reg <= tick_reg;
    assign rd_prio     = rq_rd_data[ENT_W-1:ID_W];
    assign ent_prio    = ent_reg[ENT_W-1:ID_W];
    assign stop        = rd_prio >= ent_prio;
    assign k_is_one    = k_reg == CNT_W'(1);
    assign load_out    = !out_valid_reg || rsp.ready;
    assign ins_ret     = (func_reg == FUNC_TICK) ? ST_TCK_RD : ST_TOP_RD;

    // Resize fields between port widths and internal widths
    assign prio_in_ext  = {{PRIORITY_BITS{1'b0}}, req.priority_req};
    assign req_ent      = {prio_in_ext[PRIORITY_BITS-1:0], req.thread_id};
    assign prio_out_ext = {{PRIO_W{1'b0}}, rd_prio};
    assign rcnt_ext     = {{COUNT_W{1'b0}}, ready_cnt_reg};
    assign scnt_ext     = {{COUNT_W{1'b0}}, sleep_cnt_reg};
    assign sl_rd_addr   = rd_i_reg[IDX_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func_t'(req.func))
                        FUNC_SLEEP:    state_next = ST_SLEEP;
                        FUNC_TICK:     state_next = ST_TCK_RD;
                        FUNC_READY:    state_next = ST_INS_START;
                        FUNC_DISPATCH: state_next = ST_DSP_RD;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SLEEP:   state_next = ST_TOP_RD;
            ST_TCK_RD:  state_next = sleep_done ? ST_TOP_RD : ST_TCK_CHK;
            ST_TCK_CHK: state_next = due ? ST_INS_START : ST_TCK_RD;
            ST_INS_START:
            begin
                if (ready_full)
                begin
                    state_next = ins_ret;
                end
                else
                begin
                    state_next = ready_empty ? ST_INS_PUT : ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (stop)
                begin
                    state_next = ins_ret;
                end
                else
                begin
                    state_next = k_is_one ? ST_INS_PUT : ST_INS_CMP;
                end
            end
            ST_INS_PUT: state_next = ins_ret;
            ST_DSP_RD:  state_next = ready_empty ? ST_TOP_RD : ST_DSP;
            ST_DSP:     state_next = ST_TOP_RD;
            ST_TOP_RD:  state_next = ST_TOP;
            ST_TOP:     state_next = load_out ? ST_IDLE : ST_TOP;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        func_next      = func_reg;
        ent_next       = ent_reg;
        tick_next      = tick_reg;
        ready_cnt_next = ready_cnt_reg;
        sleep_cnt_next = sleep_cnt_reg;
        rd_i_next      = rd_i_reg;
        wr_j_next      = wr_j_reg;
        k_next         = k_reg;
        earliest_next  = earliest_reg;
        min_next       = min_reg;
        err_next       = err_reg;
        res_id_next    = res_id_reg;
        found_next     = found_reg;

        out_valid_next = out_valid_reg && !rsp.ready;
        out_id_next    = out_id_reg;
        out_found_next = out_found_reg;
        out_top_next   = out_top_reg;
        out_rcnt_next  = out_rcnt_reg;
        out_scnt_next  = out_scnt_reg;
        out_wake_next  = out_wake_reg;
        out_err_next   = out_err_reg;

        rq_pop     = 1'b0;
        rq_wr_en   = 1'b0;
        rq_wr_off  = k_reg;
        rq_wr_data = ent_reg;
        rq_rd_off  = '0;

        sl_wr_en   = 1'b0;
        sl_wr_addr = sleep_cnt_reg[IDX_W-1:0];
        sl_wr_ent  = ent_reg;
        sl_wr_tick = tick_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the request and clear per-operation status
                if (accept)
                begin
                    func_next   = func_t'(req.func);
                    ent_next    = req_ent;
                    tick_next   = req.tick_value;
                    err_next    = 1'b0;
                    res_id_next = '0;
                    found_next  = 1'b0;
                    rd_i_next   = '0;
                    wr_j_next   = '0;
                    min_next    = '1;
                end
            end
            ST_SLEEP:
            begin
                // Append to the sleep list and lower the earliest wake, or flag an error when full
                if (sleep_full)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    sl_wr_en       = 1'b1;
                    sleep_cnt_next = sleep_cnt_reg + CNT_W'(1);
                    if (tick_reg < earliest_reg)
                    begin
                        earliest_next = tick_reg;
                    end
                end
            end
            ST_TCK_RD:
            begin
                // Close the walk: compacted length and minimum of the kept sleepers
                if (sleep_done)
                begin
                    sleep_cnt_next = wr_j_reg;
                    earliest_next  = min_reg;
                end
            end
            ST_TCK_CHK:
            begin
                rd_i_next = rd_i_reg + CNT_W'(1);
                if (due)
                begin
                    ent_next = sleep_rd_ent_reg;
                end
                else
                begin
                    // Keep the sleeper, packed down to the write index
                    sl_wr_en   = 1'b1;
                    sl_wr_addr = wr_j_reg[IDX_W-1:0];
                    sl_wr_ent  = sleep_rd_ent_reg;
                    sl_wr_tick = sleep_rd_tick_reg;
                    wr_j_next  = wr_j_reg + CNT_W'(1);
                    if (sleep_rd_tick_reg < min_reg)
                    begin
                        min_next = sleep_rd_tick_reg;
                    end
                end
            end
            ST_INS_START:
            begin
                if (ready_full)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    k_next    = ready_cnt_reg;
                    rq_rd_off = ready_cnt_reg - CNT_W'(1);
                end
            end
            ST_INS_CMP:
            begin
                // Stop behind an equal or higher priority, else move the entry back
                rq_wr_en = 1'b1;
                if (stop)
                begin
                    ready_cnt_next = ready_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    rq_wr_data = rq_rd_data;
                    k_next     = k_reg - CNT_W'(1);
                    rq_rd_off  = k_reg - CNT_W'(2);
                end
            end
            ST_INS_PUT:
            begin
                rq_wr_en       = 1'b1;
                ready_cnt_next = ready_cnt_reg + CNT_W'(1);
            end
            ST_DSP:
            begin
                // Pop the head word
                rq_pop         = 1'b1;
                res_id_next    = rq_rd_data[ID_W-1:0];
                found_next     = 1'b1;
                ready_cnt_next = ready_cnt_reg - CNT_W'(1);
            end
            ST_TOP:
            begin
                // Hand the status word to the response register
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_found_next = found_reg;
                    out_top_next   = ready_empty ? '0 : prio_out_ext[PRIO_W-1:0];
                    out_rcnt_next  = rcnt_ext[COUNT_W-1:0];
                    out_scnt_next  = scnt_ext[COUNT_W-1:0];
                    out_wake_next  = earliest_reg;
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_cnt_reg <= '0;
            sleep_cnt_reg <= '0;
            earliest_reg  <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ready_cnt_reg <= ready_cnt_next;
            sleep_cnt_reg <= sleep_cnt_next;
            earliest_reg  <= earliest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        ent_reg       <= ent_next;
        tick_reg      <= tick_next;
        rd_i_reg      <= rd_i_next;
        wr_j_reg      <= wr_j_next;
        k_reg         <= k_next;
        min_reg       <= min_next;
        err_reg       <= err_next;
        res_id_reg    <= res_id_next;
        found_reg     <= found_next;
        out_id_reg    <= out_id_next;
        out_found_reg <= out_found_next;
        out_top_reg   <= out_top_next;
        out_rcnt_reg  <= out_rcnt_next;
        out_scnt_reg  <= out_scnt_next;
        out_wake_reg  <= out_wake_next;
        out_err_reg   <= out_err_next;
    end

    // Sleep list storage: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (sl_wr_en)
        begin
            sleep_ent_mem[sl_wr_addr]  <= sl_wr_ent;
            sleep_tick_mem[sl_wr_addr] <= sl_wr_tick;
        end
        sleep_rd_ent_reg  <= sleep_ent_mem[sl_rd_addr];
        sleep_rd_tick_reg <= sleep_tick_mem[sl_rd_addr];
    end

    prqs_ready_ram #(
        .DEPTH (MAX_THREADS),
        .ENT_W (ENT_W)
    ) u_ready_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop     (rq_pop),
        .wr_en   (rq_wr_en),
        .wr_off  (rq_wr_off),
        .wr_data (rq_wr_data),
        .rd_off  (rq_rd_off),
        .rd_data (rq_rd_data)
    );

    // Ports
    assign req.ready         = state_reg == ST_IDLE;
    assign rsp.valid         = out_valid_reg;
    assign rsp.out_thread_id = out_id_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.top_priority  = out_top_reg;
    assign rsp.ready_count   = out_rcnt_reg;
    assign rsp.sleep_count   = out_scnt_reg;
    assign rsp.next_wake     = out_wake_reg;
    assign rsp.error         = out_err_reg;

`ifndef SYNTHESIS
    a_ready_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_cnt_reg <= CNT_W'(MAX_THREADS))
        else $error("ready count beyond capacity");

    a_sleep_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sleep_cnt_reg <= CNT_W'(MAX_THREADS))
        else $error("sleep count beyond capacity");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INS_CMP |-> (k_reg != '0 && k_reg <= ready_cnt_reg))
        else $error("insert walk index out of range");

    a_found_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> !rsp.error && rsp.ready_count < COUNT_W'(MAX_THREADS))
        else $error("dispatch response carries error or full count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DSP |-> !ready_empty)
        else $error("pop from empty ready queue");
`endif

endmodule

`default_nettype wire
